/* rtl/core/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Used by the front decoder, the command queue, the result stage and the top level.
package u8u16_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [20:0] UPPER_LIMIT_RST = 21'h0EFFFF;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [15:0] HI_SURR_BASE    = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE    = 16'hDC00;
  localparam logic [15:0] HI_SURR_ADJ     = 16'h0040;

  typedef enum logic [1:0] {
    ST_UNIT = 2'd0,
    ST_END  = 2'd1,
    ST_BAD  = 2'd2,
    ST_BIG  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_UNIT,
    OP_PAIR,
    OP_END,
    OP_BAD,
    OP_BIG
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [20:0] code;
    logic [15:0] count;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

endpackage

/* rtl/core/u8u16_front.sv */
// Front decoder: accepts UTF-8 bytes, tracks sequence state and unit count,
// and pushes one command per byte that yields results. Depends on u8u16_pkg.
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [20:0] cfg_upper_limit,
  input  logic        in_push,
  input  logic [7:0]  in_byte_in,
  input  qstat_t      q_stat,
  output logic        in_full,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic [20:0] limit_r;
  logic [30:0] acc_r, acc_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        disc_r, disc_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic        accept;
  logic [30:0] acc_cont;
  logic [2:0]  rem_dec;
  logic [30:0] cp;
  logic        emit;

  assign in_full  = q_stat.full;
  assign accept   = in_push && !q_stat.full;
  assign acc_cont = {acc_r[24:0], in_byte_in[5:0]};
  assign rem_dec  = rem_r - 3'd1;

  always_comb begin
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    disc_nxt  = disc_r;
    cnt_nxt   = cnt_r;
    cmd_push  = 1'b0;
    cmd.op    = OP_BAD;
    cmd.code  = '0;
    cmd.count = '0;
    cp        = '0;
    emit      = 1'b0;
    if (accept) begin
      if (disc_r) begin
        if (in_byte_in == 8'h00) begin
          disc_nxt = 1'b0;
          cnt_nxt  = '0;
        end
      end else if (rem_r == 3'd0) begin
        if (in_byte_in == 8'h00) begin
          cmd_push  = 1'b1;
          cmd.op    = OP_END;
          cmd.count = cnt_r;
          cnt_nxt   = '0;
        end else if (in_byte_in < 8'h80) begin
          emit = 1'b1;
          cp   = {23'd0, in_byte_in};
        end else if (in_byte_in < 8'hC0 || in_byte_in > 8'hFD) begin
          cmd_push = 1'b1;
          cmd.op   = OP_BAD;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          disc_nxt = 1'b1;
        end else if (in_byte_in < 8'hE0) begin
          acc_nxt = {26'd0, in_byte_in[4:0]};
          rem_nxt = 3'd1;
        end else if (in_byte_in < 8'hF0) begin
          acc_nxt = {27'd0, in_byte_in[3:0]};
          rem_nxt = 3'd2;
        end else if (in_byte_in < 8'hF8) begin
          acc_nxt = {28'd0, in_byte_in[2:0]};
          rem_nxt = 3'd3;
        end else if (in_byte_in < 8'hFC) begin
          acc_nxt = {29'd0, in_byte_in[1:0]};
          rem_nxt = 3'd4;
        end else begin
          acc_nxt = {30'd0, in_byte_in[0]};
          rem_nxt = 3'd5;
        end
      end else begin
        if (in_byte_in == 8'h00 || in_byte_in < 8'h80 || in_byte_in > 8'hBF) begin
          cmd_push = 1'b1;
          cmd.op   = OP_BAD;
          acc_nxt  = '0;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          disc_nxt = (in_byte_in != 8'h00);
        end else begin
          rem_nxt = rem_dec;
          if (rem_dec == 3'd0) begin
            acc_nxt = '0;
            emit    = 1'b1;
            cp      = acc_cont;
          end else begin
            acc_nxt = acc_cont;
          end
        end
      end

      if (emit) begin
        cmd_push = 1'b1;
        if (cp[30:16] == 15'd0) begin
          cmd.op    = OP_UNIT;
          cmd.code  = cp[20:0];
          cmd.count = sat_inc(cnt_r);
          cnt_nxt   = sat_inc(cnt_r);
        end else if (cp[30:21] == 10'd0 && cp[20:0] <= limit_r) begin
          cmd.op    = OP_PAIR;
          cmd.code  = cp[20:0];
          cmd.count = sat_inc(cnt_r);
          cnt_nxt   = sat_inc(sat_inc(cnt_r));
        end else begin
          cmd.op   = OP_BIG;
          acc_nxt  = '0;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          disc_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= UPPER_LIMIT_RST;
      acc_r   <= '0;
      rem_r   <= '0;
      disc_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_upper_limit;
      end
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      disc_r <= disc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/u8u16_queue.sv */
// Short command queue between the front decoder and the result stage.
// Register-based circular buffer; depends on u8u16_pkg.
module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   wr_cmd,
  input  logic   pop,
  output cmd_t   rd_cmd,
  output qstat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_FULL);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

/* rtl/core/u8u16_back.sv */
// Result stage: turns queued commands into result items, splitting
// surrogate pairs into two result items held in a registered output. Depends on u8u16_pkg.
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  qstat_t      q_stat,
  output logic        cmd_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [15:0] out_unit,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [15:0] out_unit_count
);

  logic        valid_r, valid_nxt;
  logic        half_r, half_nxt;
  logic [15:0] unit_r, unit_nxt;
  status_t     status_r, status_nxt;
  logic        last_r, last_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] lo_unit_r, lo_unit_nxt;
  logic [15:0] lo_count_r, lo_count_nxt;
  logic        advance;
  logic [15:0] hi_surr, lo_surr;

  assign advance  = !valid_r || out_pop;
  assign hi_surr  = HI_SURR_BASE + {5'd0, cmd.code[20:10]} - HI_SURR_ADJ;
  assign lo_surr  = LO_SURR_BASE + {6'd0, cmd.code[9:0]};

  assign out_empty      = !valid_r;
  assign out_unit       = unit_r;
  assign out_status     = status_r;
  assign out_last       = last_r;
  assign out_unit_count = count_r;

  always_comb begin
    valid_nxt    = valid_r;
    half_nxt     = half_r;
    unit_nxt     = unit_r;
    status_nxt   = status_r;
    last_nxt     = last_r;
    count_nxt    = count_r;
    lo_unit_nxt  = lo_unit_r;
    lo_count_nxt = lo_count_r;
    cmd_pop      = 1'b0;
    if (advance) begin
      if (half_r) begin
        valid_nxt  = 1'b1;
        half_nxt   = 1'b0;
        unit_nxt   = lo_unit_r;
        status_nxt = ST_UNIT;
        last_nxt   = 1'b1;
        count_nxt  = lo_count_r;
      end else if (!q_stat.empty) begin
        cmd_pop   = 1'b1;
        valid_nxt = 1'b1;
        last_nxt  = 1'b1;
        unit_nxt  = '0;
        count_nxt = '0;
        case (cmd.op)
          OP_UNIT: begin
            unit_nxt   = cmd.code[15:0];
            status_nxt = ST_UNIT;
            count_nxt  = cmd.count;
          end
          OP_PAIR: begin
            unit_nxt     = hi_surr;
            status_nxt   = ST_UNIT;
            count_nxt    = cmd.count;
            last_nxt     = 1'b0;
            half_nxt     = 1'b1;
            lo_unit_nxt  = lo_surr;
            lo_count_nxt = sat_inc(cmd.count);
          end
          OP_END: begin
            status_nxt = ST_END;
            count_nxt  = cmd.count;
          end
          OP_BIG: begin
            status_nxt = ST_BIG;
          end
          default: begin
            status_nxt = ST_BAD;
          end
        endcase
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r     <= unit_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
    count_r    <= count_nxt;
    lo_unit_r  <= lo_unit_nxt;
    lo_count_r <= lo_count_nxt;
  end

endmodule

/* rtl/core/utf8_to_utf16_transcoder_unit.sv */
// UTF-8 to UTF-16 transcoder, top level: one byte per push on the input
// queue side, one UTF-16 result item per pop on the output side. Bytes are
// taken one per cycle while the internal command queue has room; each
// result is registered into the output of the result stage when its command
// is popped from the queue, so a surrogate pair occupies the output for two
// result items and a run of pairs lowers the sustained byte rate only when the
// command queue (QUEUE_DEPTH entries) fills. Depends on u8u16_pkg,
// u8u16_front, u8u16_queue and u8u16_back.
module utf8_to_utf16_transcoder_unit
  import u8u16_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [20:0] cfg_upper_limit,
  input  logic        in_push,
  input  logic [7:0]  in_byte_in,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [15:0] out_unit,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [15:0] out_unit_count
);

  qstat_t q_stat;
  cmd_t   wr_cmd, rd_cmd;
  logic   cmd_push, cmd_pop;

  u8u16_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_upper_limit(cfg_upper_limit),
    .in_push        (in_push),
    .in_byte_in     (in_byte_in),
    .q_stat         (q_stat),
    .in_full        (in_full),
    .cmd_push       (cmd_push),
    .cmd            (wr_cmd)
  );

  u8u16_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wr_cmd(wr_cmd),
    .pop   (cmd_pop),
    .rd_cmd(rd_cmd),
    .stat  (q_stat)
  );

  u8u16_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (rd_cmd),
    .q_stat        (q_stat),
    .cmd_pop       (cmd_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_unit      (out_unit),
    .out_status    (out_status),
    .out_last      (out_last),
    .out_unit_count(out_unit_count)
  );

endmodule
